>>> hdl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the segment box clipper
// Widths, register indexes, pipeline payload types and the restoring
// division step used by the back end.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int COORD_BITS    = 32;
  localparam int T_FRAC_BITS   = 16;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int T_BITS        = T_FRAC_BITS + 1;
  localparam int HI_BITS       = DIFF_BITS - T_FRAC_BITS;
  localparam int PH_BITS       = HI_BITS + T_BITS;
  localparam int PL_BITS       = 2 * T_FRAC_BITS;
  localparam int SMAG_BITS     = PH_BITS + 1;
  localparam int SUM_BITS      = SMAG_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int NUM_LANES     = 6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [DIFF_BITS-1:0]         mag_t;
  typedef logic [T_BITS-1:0]            tval_t;
  typedef logic [T_FRAC_BITS-1:0]       quot_t;

  localparam tval_t T_ONE = tval_t'(1) << T_FRAC_BITS;

  typedef struct packed {
    coord_t [2:0] mn;
    coord_t [2:0] mx;
  } box_t;

  // Lanes 0..2 hold the lower plane numerators, lanes 3..5 the upper ones.
  typedef struct packed {
    coord_t [2:0]           s;
    diff_t [2:0]            d;
    diff_t [NUM_LANES-1:0]  n;
    logic                   rej;
  } item_t;

  typedef struct packed {
    logic  zr;
    logic  sat;
    mag_t  r;
    mag_t  dm;
    quot_t q;
  } lane_t;

  typedef struct packed {
    coord_t [2:0]          s;
    diff_t [2:0]           d;
    logic                  rej;
    lane_t [NUM_LANES-1:0] ln;
  } div_t;

  function automatic mag_t mag(diff_t v);
    mag_t m;
    m = v[DIFF_BITS-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

  // One bit of restoring division.
  function automatic lane_t div_step(lane_t a);
    logic [DIFF_BITS:0] sh;
    lane_t              b;
    b  = a;
    sh = {a.r, 1'b0};
    if (sh >= {1'b0, a.dm}) begin
      b.r = DIFF_BITS'(sh - {1'b0, a.dm});
      b.q = {a.q[T_FRAC_BITS-2:0], 1'b1};
    end else begin
      b.r = sh[DIFF_BITS-1:0];
      b.q = {a.q[T_FRAC_BITS-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

>>> hdl/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_if: segment and result channels
// Valid/ready channels carrying one segment word and one result word.
// ----------------------------------------------------------------------------
interface sbc_in_if;
  logic                 valid;
  logic                 ready;
  sbc_pkg::coord_t      start_x;
  sbc_pkg::coord_t      start_y;
  sbc_pkg::coord_t      start_z;
  sbc_pkg::coord_t      end_x;
  sbc_pkg::coord_t      end_y;
  sbc_pkg::coord_t      end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface sbc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 inside_res;
  sbc_pkg::coord_t      clip_start_x;
  sbc_pkg::coord_t      clip_start_y;
  sbc_pkg::coord_t      clip_start_z;
  sbc_pkg::coord_t      clip_end_x;
  sbc_pkg::coord_t      clip_end_y;
  sbc_pkg::coord_t      clip_end_z;
  modport source (output valid, inside_res, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, input ready);
  modport sink   (input valid, inside_res, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

>>> hdl/segment_box_clipper_3d_top.sv
// ----------------------------------------------------------------------------
// segment_box_clipper_3d_top: 3D segment clipper against a box
// Clips one segment word per cycle, unless stalled, against six box registers.
// ----------------------------------------------------------------------------
// Path from segment accept to result valid: front register, queue, divider
// entry, 16 divider stages, interval, product, sum and output registers.
// Throughput: one segment word per cycle while the sink takes results, set
// by the fully pipelined one-bit-per-stage dividers.
// Reset: asynchronous, active low; clears the box registers to zero and
// empties the front register, the queue and every pipeline stage.
// ----------------------------------------------------------------------------
module segment_box_clipper_3d_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sbc_pkg::COORD_BITS-1:0]     cfg_wdata_i,
  sbc_in_if.sink                             seg_i,
  sbc_out_if.source                          res_o
);

  // The box corner registers. A write to an index past the six is dropped.
  sbc_pkg::box_t box_d, box_q;

  // Front to queue and queue to back.
  sbc_pkg::item_t f_item, q_item;
  logic           f_valid, f_ready;
  logic           q_valid, q_ready;

  always_comb begin
    box_d = box_q;
    if (cfg_we_i) begin
      case (sbc_pkg::cfg_reg_e'(cfg_idx_i))
        sbc_pkg::REG_BOX_MIN_X: box_d.mn[0] = cfg_wdata_i;
        sbc_pkg::REG_BOX_MIN_Y: box_d.mn[1] = cfg_wdata_i;
        sbc_pkg::REG_BOX_MIN_Z: box_d.mn[2] = cfg_wdata_i;
        sbc_pkg::REG_BOX_MAX_X: box_d.mx[0] = cfg_wdata_i;
        sbc_pkg::REG_BOX_MAX_Y: box_d.mx[1] = cfg_wdata_i;
        sbc_pkg::REG_BOX_MAX_Z: box_d.mx[2] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  // The front takes a segment word, forms the deltas and plane numerators
  // and flags still axes that lie outside their slab.
  sbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_i        (seg_i),
    .box_i        (box_q),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  // The queue lets the front keep taking words while the back is stalled.
  sbc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (f_item),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  // The back divides, intersects the interval, scales the endpoints and
  // holds the result word until the sink takes it.
  sbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .res_o        (res_o)
  );

endmodule

>>> hdl/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front: segment intake and classification
// Registers each segment with its deltas, plane numerators and the
// zero-extent reject flag.
// ----------------------------------------------------------------------------
module sbc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbc_in_if.sink         seg_i,
  input  sbc_pkg::box_t  box_i,
  output sbc_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);

  sbc_pkg::item_t  item_d, item_q;
  logic            fv_d, fv_q;
  logic            accept;
  sbc_pkg::coord_t s_c [3];
  sbc_pkg::coord_t e_c [3];

  assign seg_i.ready = !fv_q || item_ready_i;
  assign accept      = seg_i.valid && seg_i.ready;

  always_comb begin
    s_c[0] = seg_i.start_x;
    s_c[1] = seg_i.start_y;
    s_c[2] = seg_i.start_z;
    e_c[0] = seg_i.end_x;
    e_c[1] = seg_i.end_y;
    e_c[2] = seg_i.end_z;
    item_d = '0;
    for (int a = 0; a < 3; a++) begin
      item_d.s[a]     = s_c[a];
      item_d.d[a]     = sbc_pkg::DIFF_BITS'(e_c[a]) - sbc_pkg::DIFF_BITS'(s_c[a]);
      item_d.n[a]     = sbc_pkg::DIFF_BITS'($signed(box_i.mn[a]))
                        - sbc_pkg::DIFF_BITS'(s_c[a]);
      item_d.n[a + 3] = sbc_pkg::DIFF_BITS'($signed(box_i.mx[a]))
                        - sbc_pkg::DIFF_BITS'(s_c[a]);
      // A still axis rejects when its start lies outside the slab.
      if (e_c[a] == s_c[a] &&
          (s_c[a] < $signed(box_i.mn[a]) || s_c[a] > $signed(box_i.mx[a]))) begin
        item_d.rej = 1'b1;
      end
    end
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (item_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = fv_q;

endmodule

>>> hdl/sbc_fifo.sv
// ----------------------------------------------------------------------------
// sbc_fifo: queue between front and back
// Small flop-based first-in first-out buffer of classified segments.
// ----------------------------------------------------------------------------
module sbc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbc_pkg::item_t push_item_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output sbc_pkg::item_t pop_item_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  sbc_pkg::item_t                    mem_q [sbc_pkg::FIFO_DEPTH];
  logic [sbc_pkg::FIFO_PTR_BITS-1:0] wr_d, wr_q, rd_d, rd_q;
  logic [sbc_pkg::FIFO_PTR_BITS:0]   cnt_d, cnt_q;
  logic                              push, pop;

  assign push_ready_o = cnt_q != (sbc_pkg::FIFO_PTR_BITS + 1)'(sbc_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/sbc_back.sv
// ----------------------------------------------------------------------------
// sbc_back: clipping pipeline
// Six pipelined dividers give the plane crossings, then the interval is
// intersected, endpoints are scaled and the result word is registered.
// ----------------------------------------------------------------------------
module sbc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sbc_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  sbc_out_if.source      res_o
);

  localparam int NDIV = sbc_pkg::T_FRAC_BITS;

  logic en;

  // Divider stages.
  sbc_pkg::div_t div_q [NDIV+1];
  sbc_pkg::div_t div_nx [NDIV];
  sbc_pkg::div_t div_in;
  logic [NDIV:0] dv_q;

  // Interval stage.
  logic                    tv_q;
  sbc_pkg::tval_t          tmin_d, tmax_d, tmin_q, tmax_q;
  sbc_pkg::coord_t [2:0]   ts_q;
  sbc_pkg::diff_t [2:0]    td_q;
  logic                    trej_d, trej_q;

  // Product stage.
  logic                              mv_q;
  logic [sbc_pkg::PH_BITS-1:0]       ph_d [2][3];
  logic [sbc_pkg::PH_BITS-1:0]       ph_q [2][3];
  logic [sbc_pkg::PL_BITS-1:0]       pl_d [2][3];
  logic [sbc_pkg::PL_BITS-1:0]       pl_q [2][3];
  logic [2:0]                        neg_q;
  sbc_pkg::coord_t [2:0]             ms_q;
  logic                              mrej_q;

  // Sum stage.
  logic                  av_q;
  sbc_pkg::coord_t [2:0] cs_d, ce_d, cs_q, ce_q;
  logic                  arej_q;

  // Output register.
  logic                  ov_q;
  logic                  oin_d, oin_q;
  sbc_pkg::coord_t [2:0] ocs_q, oce_q;

  assign en           = !ov_q || res_o.ready;
  assign item_ready_o = en;

  // Divider entry: signs, magnitudes and saturation.
  always_comb begin
    sbc_pkg::diff_t num, den;
    sbc_pkg::mag_t  nm, dmg;
    div_in     = '0;
    div_in.s   = item_i.s;
    div_in.d   = item_i.d;
    div_in.rej = item_i.rej;
    for (int l = 0; l < sbc_pkg::NUM_LANES; l++) begin
      num = item_i.n[l];
      den = item_i.d[l % 3];
      nm  = sbc_pkg::mag(num);
      dmg = sbc_pkg::mag(den);
      div_in.ln[l].zr  = (num == '0) ||
                         (num[sbc_pkg::DIFF_BITS-1] != den[sbc_pkg::DIFF_BITS-1]);
      div_in.ln[l].sat = nm >= dmg;
      div_in.ln[l].r   = nm;
      div_in.ln[l].dm  = dmg;
      div_in.ln[l].q   = '0;
    end
  end

  // Next contents of each divider stage: the word moves on and every lane
  // takes one more quotient bit.
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      div_nx[k] = div_q[k];
      for (int l = 0; l < sbc_pkg::NUM_LANES; l++) begin
        div_nx[k].ln[l] = sbc_pkg::div_step(div_q[k].ln[l]);
      end
    end
  end

  // Clamp crossings, order each slab and intersect with [0,1].
  always_comb begin
    sbc_pkg::tval_t t0, t1, lo, hi;
    tmin_d = '0;
    tmax_d = sbc_pkg::T_ONE;
    for (int a = 0; a < 3; a++) begin
      t0 = div_q[NDIV].ln[a].zr ? '0 :
           (div_q[NDIV].ln[a].sat ? sbc_pkg::T_ONE : {1'b0, div_q[NDIV].ln[a].q});
      t1 = div_q[NDIV].ln[a+3].zr ? '0 :
           (div_q[NDIV].ln[a+3].sat ? sbc_pkg::T_ONE : {1'b0, div_q[NDIV].ln[a+3].q});
      lo = (t0 > t1) ? t1 : t0;
      hi = (t0 > t1) ? t0 : t1;
      if (div_q[NDIV].d[a] != '0) begin
        if (lo > tmin_d) tmin_d = lo;
        if (hi < tmax_d) tmax_d = hi;
      end
    end
    trej_d = div_q[NDIV].rej || (tmin_d > tmax_d);
  end

  // |delta| * t, split into a high and a low partial product.
  always_comb begin
    sbc_pkg::mag_t               m;
    logic [sbc_pkg::PH_BITS-1:0] hx, th;
    logic [sbc_pkg::PL_BITS-1:0] lx, tl;
    for (int a = 0; a < 3; a++) begin
      m  = sbc_pkg::mag(td_q[a]);
      hx = sbc_pkg::PH_BITS'(m[sbc_pkg::DIFF_BITS-1:sbc_pkg::T_FRAC_BITS]);
      lx = sbc_pkg::PL_BITS'(m[sbc_pkg::T_FRAC_BITS-1:0]);
      for (int k = 0; k < 2; k++) begin
        th = sbc_pkg::PH_BITS'(k == 0 ? tmin_q : tmax_q);
        tl = sbc_pkg::PL_BITS'(k == 0 ? tmin_q : tmax_q);
        ph_d[k][a] = hx * th;
        pl_d[k][a] = lx * tl + (sbc_pkg::PL_BITS'(1) << (sbc_pkg::T_FRAC_BITS - 1));
      end
    end
  end

  // Rounded product added to the start point.
  always_comb begin
    logic [sbc_pkg::SMAG_BITS-1:0]       sm;
    logic signed [sbc_pkg::SUM_BITS-1:0] sum;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 2; k++) begin
        sm  = sbc_pkg::SMAG_BITS'(ph_q[k][a])
              + sbc_pkg::SMAG_BITS'(pl_q[k][a] >> sbc_pkg::T_FRAC_BITS);
        sum = sbc_pkg::SUM_BITS'($signed(ms_q[a]));
        if (neg_q[a]) begin
          sum = sum - $signed({1'b0, sm});
        end else begin
          sum = sum + $signed({1'b0, sm});
        end
        if (k == 0) cs_d[a] = sum[sbc_pkg::COORD_BITS-1:0];
        else        ce_d[a] = sum[sbc_pkg::COORD_BITS-1:0];
      end
    end
  end

  assign oin_d = !arej_q && (cs_q != ce_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      tv_q <= 1'b0;
      mv_q <= 1'b0;
      av_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      dv_q <= {dv_q[NDIV-1:0], item_valid_i};
      tv_q <= dv_q[NDIV];
      mv_q <= tv_q;
      av_q <= mv_q;
      ov_q <= av_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_in;
      for (int k = 0; k < NDIV; k++) begin
        div_q[k+1] <= div_nx[k];
      end
      tmin_q <= tmin_d;
      tmax_q <= tmax_d;
      ts_q   <= div_q[NDIV].s;
      td_q   <= div_q[NDIV].d;
      trej_q <= trej_d;
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      for (int a = 0; a < 3; a++) begin
        neg_q[a] <= td_q[a][sbc_pkg::DIFF_BITS-1];
      end
      ms_q   <= ts_q;
      mrej_q <= trej_q;
      cs_q   <= cs_d;
      ce_q   <= ce_d;
      arej_q <= mrej_q;
      oin_q  <= oin_d;
      ocs_q  <= oin_d ? cs_q : '0;
      oce_q  <= oin_d ? ce_q : '0;
    end
  end

  assign res_o.valid        = ov_q;
  assign res_o.inside_res   = oin_q;
  assign res_o.clip_start_x = ocs_q[0];
  assign res_o.clip_start_y = ocs_q[1];
  assign res_o.clip_start_z = ocs_q[2];
  assign res_o.clip_end_x   = oce_q[0];
  assign res_o.clip_end_y   = oce_q[1];
  assign res_o.clip_end_z   = oce_q[2];

endmodule
